// ----- sv/pssr_pkg.sv -----
package pssr_pkg;

  // default raster and brush limits
  localparam int DEF_MAX_ROWS       = 256;
  localparam int DEF_MAX_COLS       = 256;
  localparam int DEF_MAX_POINT_SIZE = 15;

  // fixed widths from the field and limit ranges
  localparam int DIM_W  = 13;  // holds a raster dimension up to 4096
  localparam int POS_W  = 17;  // signed grid position with brush offset
  localparam int SIZE_W = 6;   // brush side up to 63
  localparam int VAL_W  = 32;
  localparam int CFG_W  = 9;

  localparam logic [VAL_W-1:0] UNDEF_CELL = 32'h8000_0000;
  localparam logic [VAL_W-1:0] CELL_MAX   = 32'h7fff_ffff;
  localparam logic [VAL_W-1:0] CELL_MIN   = 32'h8000_0001;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_POINT = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_COUNT = 2'd1,
    MODE_SUM   = 2'd2,
    MODE_ALT   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_MODE       = 2'd0,
    REG_POINT_SIZE = 2'd1,
    REG_ROWS       = 2'd2,
    REG_COLS       = 2'd3
  } reg_idx_t;

  // microprogram steps
  typedef enum logic [2:0] {
    S_IDLE     = 3'd0,
    S_CLR_INIT = 3'd1,
    S_CLR_WR   = 3'd2,
    S_PT_INIT  = 3'd3,
    S_PT_RD    = 3'd4,
    S_PT_WR    = 3'd5,
    S_RD_ADDR  = 3'd6,
    S_RD_OUT   = 3'd7
  } step_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_CLR_INIT,
    OP_CLR_WRITE,
    OP_PT_INIT,
    OP_PT_READ,
    OP_PT_WRITE,
    OP_RD_READ,
    OP_RD_OUT
  } op_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_DISPATCH,
    C_EMPTY,
    C_CLR_LAST,
    C_PT_LAST
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t taken;
    step_t fall;
  } uword_t;

  function automatic uword_t ucode_rom(input step_t step);
    uword_t w;
    case (step)
      S_IDLE:     w = '{OP_NOP,       C_DISPATCH, S_IDLE,   S_IDLE};
      S_CLR_INIT: w = '{OP_CLR_INIT,  C_EMPTY,    S_IDLE,   S_CLR_WR};
      S_CLR_WR:   w = '{OP_CLR_WRITE, C_CLR_LAST, S_IDLE,   S_CLR_WR};
      S_PT_INIT:  w = '{OP_PT_INIT,   C_ALWAYS,   S_PT_RD,  S_PT_RD};
      S_PT_RD:    w = '{OP_PT_READ,   C_ALWAYS,   S_PT_WR,  S_PT_WR};
      S_PT_WR:    w = '{OP_PT_WRITE,  C_PT_LAST,  S_IDLE,   S_PT_RD};
      S_RD_ADDR:  w = '{OP_RD_READ,   C_ALWAYS,   S_RD_OUT, S_RD_OUT};
      S_RD_OUT:   w = '{OP_RD_OUT,    C_ALWAYS,   S_IDLE,   S_IDLE};
      default:    w = '{OP_NOP,       C_ALWAYS,   S_IDLE,   S_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ----- sv/point_square_splat_rasterizer.sv -----
// read request: address step, output step, then the registered result strobe
// point request: init step, then read and write steps per cell; outside cells unwritten
// clear request: init step, then a raster sweep, one cell written per cycle
// point rate is set by the read-modify-write of each cell, a read step then a write step
// synchronous reset returns the sequencer to idle and the registers to mode 0, size 1,
// 256 by 256; raster contents are not cleared by reset, results cannot be stalled
module point_square_splat_rasterizer #(
  parameter int MAX_ROWS       = pssr_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS       = pssr_pkg::DEF_MAX_COLS,
  parameter int MAX_POINT_SIZE = pssr_pkg::DEF_MAX_POINT_SIZE
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     command,
  input  logic                           point_valid,
  input  logic signed [15:0]             grid_row,
  input  logic signed [15:0]             grid_col,
  input  logic signed [pssr_pkg::VAL_W-1:0] point_value,
  input  logic                           wr_en,
  input  logic [1:0]                     wr_index,
  input  logic [pssr_pkg::CFG_W-1:0]     wr_data,
  output logic                           result_strobe,
  output logic signed [pssr_pkg::VAL_W-1:0] cell_value,
  output logic                           cell_inside
);

  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AW = RW + CW;
  localparam int DEPTH = 2 ** AW;
  localparam logic [pssr_pkg::DIM_W-1:0]  ROWS_LIM = pssr_pkg::DIM_W'(MAX_ROWS);
  localparam logic [pssr_pkg::DIM_W-1:0]  COLS_LIM = pssr_pkg::DIM_W'(MAX_COLS);
  localparam logic [pssr_pkg::SIZE_W-1:0] SIZE_LIM = pssr_pkg::SIZE_W'(MAX_POINT_SIZE);

  // configuration registers
  logic [1:0]                mode;
  logic [3:0]                point_size;
  logic [pssr_pkg::CFG_W-1:0] rows_in_use;
  logic [pssr_pkg::CFG_W-1:0] cols_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= pssr_pkg::MODE_WRITE;
      point_size  <= 4'd1;
      rows_in_use <= 9'd256;
      cols_in_use <= 9'd256;
    end else if (wr_en) begin
      case (pssr_pkg::reg_idx_t'(wr_index))
        pssr_pkg::REG_MODE:       mode        <= wr_data[1:0];
        pssr_pkg::REG_POINT_SIZE: point_size  <= wr_data[3:0];
        pssr_pkg::REG_ROWS:       rows_in_use <= wr_data;
        pssr_pkg::REG_COLS:       cols_in_use <= wr_data;
        default: ;
      endcase
    end
  end

  // clamped dimensions and brush size
  logic [pssr_pkg::DIM_W-1:0]  nr, nc, nr_ext, nc_ext;
  logic [pssr_pkg::SIZE_W-1:0] ps_ext, size, half;

  assign nr_ext = pssr_pkg::DIM_W'(rows_in_use);
  assign nc_ext = pssr_pkg::DIM_W'(cols_in_use);
  assign nr     = (nr_ext > ROWS_LIM) ? ROWS_LIM : nr_ext;
  assign nc     = (nc_ext > COLS_LIM) ? COLS_LIM : nc_ext;
  assign ps_ext = pssr_pkg::SIZE_W'(point_size);
  assign size   = (point_size == 4'd0) ? pssr_pkg::SIZE_W'(1) :
                  ((ps_ext > SIZE_LIM) ? SIZE_LIM : ps_ext);
  assign half   = size >> 1;

  // sequencer
  pssr_pkg::step_t  upc, upc_next;
  pssr_pkg::uword_t uw;
  logic             accept;
  logic             in_empty, clr_last, pt_last;

  // datapath registers
  logic signed [pssr_pkg::POS_W-1:0] r, c, col0;
  logic [pssr_pkg::SIZE_W-1:0]       ri, ci;
  logic signed [pssr_pkg::VAL_W-1:0] val;
  logic [pssr_pkg::VAL_W-1:0]        rdata;
  logic                              inside_q;

  assign busy   = (upc != pssr_pkg::S_IDLE);
  assign accept = start && !busy;
  assign uw     = pssr_pkg::ucode_rom(upc);

  assign in_empty = (nr == '0) || (nc == '0);
  assign clr_last = (r[pssr_pkg::DIM_W-1:0] == nr - 1'b1) &&
                    (c[pssr_pkg::DIM_W-1:0] == nc - 1'b1);
  assign pt_last  = (ri == size - 1'b1) && (ci == size - 1'b1);

  always_comb begin
    upc_next = uw.fall;
    case (uw.cond)
      pssr_pkg::C_ALWAYS:   upc_next = uw.taken;
      pssr_pkg::C_EMPTY:    upc_next = in_empty ? uw.taken : uw.fall;
      pssr_pkg::C_CLR_LAST: upc_next = clr_last ? uw.taken : uw.fall;
      pssr_pkg::C_PT_LAST:  upc_next = pt_last ? uw.taken : uw.fall;
      pssr_pkg::C_DISPATCH: begin
        upc_next = pssr_pkg::S_IDLE;
        if (accept) begin
          case (pssr_pkg::cmd_t'(command))
            pssr_pkg::CMD_CLEAR: upc_next = pssr_pkg::S_CLR_INIT;
            pssr_pkg::CMD_POINT: upc_next = point_valid ? pssr_pkg::S_PT_INIT
                                                        : pssr_pkg::S_IDLE;
            pssr_pkg::CMD_READ:  upc_next = pssr_pkg::S_RD_ADDR;
            default:             upc_next = pssr_pkg::S_IDLE;
          endcase
        end
      end
      default: upc_next = pssr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= pssr_pkg::S_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

  // cell address and clipping test on the current position
  logic [AW-1:0] addr;
  logic          pos_inside;

  assign addr       = {r[RW-1:0], c[CW-1:0]};
  assign pos_inside = !r[pssr_pkg::POS_W-1] && !c[pssr_pkg::POS_W-1] &&
                      (r[15:0] < 16'(nr)) && (c[15:0] < 16'(nc));

  // position counters
  always_ff @(posedge clk) begin
    if (accept) begin
      r   <= pssr_pkg::POS_W'(grid_row);
      c   <= pssr_pkg::POS_W'(grid_col);
      val <= point_value;
    end else begin
      case (uw.op)
        pssr_pkg::OP_CLR_INIT: begin
          r <= '0;
          c <= '0;
        end
        pssr_pkg::OP_CLR_WRITE: begin
          if (c[pssr_pkg::DIM_W-1:0] == nc - 1'b1) begin
            c <= '0;
            r <= r + 1'b1;
          end else begin
            c <= c + 1'b1;
          end
        end
        pssr_pkg::OP_PT_INIT: begin
          r    <= r - pssr_pkg::POS_W'(half);
          c    <= c - pssr_pkg::POS_W'(half);
          col0 <= c - pssr_pkg::POS_W'(half);
          ri   <= '0;
          ci   <= '0;
        end
        pssr_pkg::OP_PT_WRITE: begin
          if (ci == size - 1'b1) begin
            ci <= '0;
            c  <= col0;
            ri <= ri + 1'b1;
            r  <= r + 1'b1;
          end else begin
            ci <= ci + 1'b1;
            c  <= c + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // new cell value for a point
  logic [pssr_pkg::VAL_W-1:0] fill, upd;
  logic signed [pssr_pkg::VAL_W:0] acc, addend;

  assign fill = (mode == pssr_pkg::MODE_COUNT || mode == pssr_pkg::MODE_SUM) ?
                '0 : pssr_pkg::UNDEF_CELL;
  assign addend = (mode == pssr_pkg::MODE_COUNT) ? 33'sd1 : 33'(val);
  assign acc    = $signed({rdata[pssr_pkg::VAL_W-1], rdata}) + addend;

  always_comb begin
    if (mode == pssr_pkg::MODE_COUNT || mode == pssr_pkg::MODE_SUM) begin
      if (rdata == pssr_pkg::UNDEF_CELL) begin
        upd = rdata;  // undefined cells stay undefined
      end else if (acc > $signed({1'b0, pssr_pkg::CELL_MAX})) begin
        upd = pssr_pkg::CELL_MAX;
      end else if (acc < $signed({1'b1, pssr_pkg::CELL_MIN})) begin
        upd = pssr_pkg::CELL_MIN;
      end else begin
        upd = acc[pssr_pkg::VAL_W-1:0];
      end
    end else begin
      upd = val;
    end
  end

  // raster memory
  logic [pssr_pkg::VAL_W-1:0] cell_mem [DEPTH];
  logic                       mem_we;
  logic [pssr_pkg::VAL_W-1:0] mem_wdata;

  assign mem_we    = (uw.op == pssr_pkg::OP_CLR_WRITE) ||
                     ((uw.op == pssr_pkg::OP_PT_WRITE) && inside_q);
  assign mem_wdata = (uw.op == pssr_pkg::OP_CLR_WRITE) ? fill : upd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cell_mem[addr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata    <= cell_mem[addr];
    inside_q <= pos_inside;
  end

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= (uw.op == pssr_pkg::OP_RD_OUT);
    end
  end

  always_ff @(posedge clk) begin
    if (uw.op == pssr_pkg::OP_RD_OUT) begin
      cell_value  <= inside_q ? rdata : '0;
      cell_inside <= inside_q;
    end
  end

`ifndef NO_ASSERTIONS
  a_strobe_from_out_step: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> $past(upc == pssr_pkg::S_RD_OUT))
    else $error("result strobe without output step");

  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    result_strobe |=> !result_strobe)
    else $error("result strobe held for two cycles");

  a_read_latency: assert property (@(posedge clk) disable iff (rst)
    (accept && command == pssr_pkg::CMD_READ) |-> ##3 result_strobe)
    else $error("read request gave no result in time");

  a_busy_on_accept: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("sequencer left idle without a request");

  a_write_in_raster: assert property (@(posedge clk) disable iff (rst)
    (uw.op == pssr_pkg::OP_CLR_WRITE) |-> pos_inside)
    else $error("clear sweep outside the raster in use");
`endif

endmodule
